### hdl/alt_service_candidate_cache_defines.svh
// assertion macros used by the checker file of the alternative service cache
`ifndef ALT_SERVICE_CANDIDATE_CACHE_DEFINES_SVH
`define ALT_SERVICE_CANDIDATE_CACHE_DEFINES_SVH

// same-cycle implication, disabled while rst_n is low
`define ASC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while rst_n is low
`define ASC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/asc_pkg.sv
// types and constants of the alternative service candidate cache
`timescale 1ns / 1ps

package asc_pkg;

    localparam int IN_DATA_W  = 216;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 88;
    localparam int CFG_DATA_W = 22;
    localparam int FAMILIES   = 3;
    localparam int BO_W       = 24;

    localparam logic [4:0]  CAP_RESET      = 5'd16;
    localparam logic [15:0] INIT_BO_RESET  = 16'd1000;
    localparam logic [21:0] MAX_BO_RESET   = 22'd60000;

    localparam logic [1:0] REG_CAPACITY   = 2'd0;
    localparam logic [1:0] REG_INIT_BO    = 2'd1;
    localparam logic [1:0] REG_MAX_BO     = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_IGN  = 2'd2;

    localparam logic [1:0] KIND_IGNORED = 2'd0;
    localparam logic [1:0] KIND_NETWORK = 2'd1;

    localparam logic [1:0] FAM_ANY  = 2'd0;
    localparam logic [1:0] FAM_IPV4 = 2'd1;
    localparam logic [1:0] FAM_IPV6 = 2'd2;

    localparam logic [2:0] ACT_STORE   = 3'd0;
    localparam logic [2:0] ACT_CLEAR   = 3'd1;
    localparam logic [2:0] ACT_LOOKUP  = 3'd2;
    localparam logic [2:0] ACT_FAIL    = 3'd3;
    localparam logic [2:0] ACT_SUCCESS = 3'd4;
    localparam logic [2:0] ACT_NETCHG  = 3'd5;

    typedef enum logic [2:0] {
        OP_STORE,
        OP_CLEAR,
        OP_LOOKUP,
        OP_FAIL,
        OP_SUCCESS,
        OP_NETCHG,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [1:0]  fam;
        logic [31:0] key;
        logic [47:0] now;
        logic [1:0]  pos;
        logic [31:0] gen;
        logic [31:0] host;
        logic [15:0] port;
        logic [47:0] expires;
        logic        persist;
        logic        last;
        logic [1:0]  kind;
    } item_t;

    typedef struct packed {
        logic [15:0] init_bo;
        logic [21:0] max_bo;
    } cfg_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] gen;
        logic [47:0] updated;
        logic [2:0]  count;
    } ent_t;

    typedef struct packed {
        logic [31:0] host;
        logic [15:0] port;
        logic [47:0] expires;
        logic        persist;
    } cand_t;

    typedef struct packed {
        logic [47:0] blk_until;
        logic [7:0]  fails;
        logic        disabled;
    } brk_fam_t;

    typedef brk_fam_t [FAMILIES-1:0] brk_t;

    typedef struct packed {
        logic        persist;
        logic [1:0]  idx;
        logic [31:0] gen;
        logic [15:0] port;
        logic [31:0] host;
        logic [1:0]  status;
    } result_t;

    typedef enum logic [3:0] {
        E_IDLE,
        E_SCAN_RD,
        E_SCAN_CHK,
        E_DISPATCH,
        E_BUILD_RD,
        E_BUILD_CHK,
        E_CAND_RD,
        E_CAND_CHK,
        E_MARK_RD,
        E_MARK_CHK,
        E_BACKOFF,
        E_MARK_WR,
        E_NC_RD,
        E_NC_CHK,
        E_NC_CLR,
        E_RESP
    } eng_state_t;

endpackage

### hdl/alt_service_candidate_cache.sv
// top level of the alternative service candidate cache
`timescale 1ns / 1ps

// Origin-keyed cache of alternative endpoints. Each item on the s_ side carries
// an action in s_tuser (store candidate, clear origin, lookup, mark failure,
// mark success, network changed); every item gives exactly one result on the
// m_ side, in order. A two-deep input queue takes items while the engine works
// and while a result waits in the output register. Timing per item is set by
// the engine's walk over the entry memory, a read and a check per searched
// entry (capacity, at most ENTRIES). A store that opens a run, a clear and a
// lookup scan every searched entry; a lookup of a present origin then reads and
// checks each candidate inspected. A mark that applies scans, then reads and
// checks the candidate's state; a network failure then doubles the backoff
// once per step (at most fail_count - 1 times, none once the limit is reached)
// before it writes the block time. An ignored failure kind and an unknown
// action skip the walk, and a store that continues a run reads only its run's
// entry. A network change reads each entry and clears every stored candidate
// of valid entries. While an earlier result still waits on m_tready the engine
// holds in its last step. There is no clearing pass after reset: entry valid
// bits reset at once, and every candidate's broken state is cleared when the
// candidate is stored.
module alt_service_candidate_cache
    import asc_pkg::*;
#(
    parameter int ENTRIES        = 16,
    parameter int MAX_CANDIDATES = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // key[31:0] now[79:32] family[81:80] cand_index[83:82] generation[115:84]
    // alt_host_id[147:116] alt_port[163:148] expires_at_ms[211:164] persist[212]
    // failure_kind[214:213], zero pad above
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,   // action[2:0]
    input  logic                  s_tlast,   // last candidate of a store run
    // status[1:0] found_host_id[33:2] found_port[49:34] found_generation[81:50]
    // found_index[83:82] found_persist[84], zero pad above
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    // configuration writes: index 0 capacity, 1 initial backoff, 2 max backoff
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int NW = $clog2(ENTRIES + 1);

    logic [4:0]  cap_reg;
    logic [15:0] init_bo_reg;
    logic [21:0] max_bo_reg;
    cfg_t        cfg;
    logic [NW-1:0] used;

    logic    q_valid, q_pop;
    item_t   q_item;
    result_t res;

    // config registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            init_bo_reg <= INIT_BO_RESET;
            max_bo_reg  <= MAX_BO_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CAPACITY: cap_reg     <= cfg_wdata[4:0];
                REG_INIT_BO:  init_bo_reg <= cfg_wdata[15:0];
                REG_MAX_BO:   max_bo_reg  <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // entries searched: capacity clamped to 1..ENTRIES
    always_comb begin
        if (cap_reg == 5'd0) begin
            used = NW'(1);
        end else if (32'(cap_reg) > ENTRIES) begin
            used = NW'(ENTRIES);
        end else begin
            used = NW'(cap_reg);
        end
        cfg.init_bo = init_bo_reg;
        cfg.max_bo  = max_bo_reg;
    end

    asc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    asc_engine #(
        .ENTRIES        (ENTRIES),
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .used      (used),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res       (res),
        .res_ready (m_tready)
    );

    // result fields packed from bit 0 up, pad bits zero
    assign m_tdata = {3'b000, res};

endmodule

### hdl/asc_front.sv
// input side: takes items, decodes the action and queues them for the engine
`timescale 1ns / 1ps

module asc_front
    import asc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [IN_USER_W-1:0] s_tuser,
    input  logic                 s_tlast,
    output logic                 q_valid,
    output item_t                q_item,
    input  logic                 q_pop
);

    item_t      q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    item_t      dec;
    logic       push;
    logic [1:0] famcode;

    always_comb begin
        famcode     = s_tdata[81:80];
        dec.key     = s_tdata[31:0];
        dec.now     = s_tdata[79:32];
        dec.pos     = s_tdata[83:82];
        dec.gen     = s_tdata[115:84];
        dec.host    = s_tdata[147:116];
        dec.port    = s_tdata[163:148];
        dec.expires = s_tdata[211:164];
        dec.persist = s_tdata[212];
        dec.kind    = s_tdata[214:213];
        dec.last    = s_tlast;
        dec.fam     = (famcode == FAM_IPV4 || famcode == FAM_IPV6) ? famcode : FAM_ANY;
        unique case (s_tuser)
            ACT_STORE:   dec.op = OP_STORE;
            ACT_CLEAR:   dec.op = OP_CLEAR;
            ACT_LOOKUP:  dec.op = OP_LOOKUP;
            ACT_FAIL:    dec.op = OP_FAIL;
            ACT_SUCCESS: dec.op = OP_SUCCESS;
            ACT_NETCHG:  dec.op = OP_NETCHG;
            default:     dec.op = OP_BAD;
        endcase
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### hdl/asc_engine.sv
// back side: sequencer over the entry, candidate and broken-state memories
`timescale 1ns / 1ps

module asc_engine
    import asc_pkg::*;
#(
    parameter int ENTRIES        = 16,
    parameter int MAX_CANDIDATES = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  cfg_t                               cfg,
    input  logic [$clog2(ENTRIES+1)-1:0]       used,
    input  logic                               q_valid,
    input  item_t                              q_item,
    output logic                               q_pop,
    output logic                               res_valid,
    output result_t                            res,
    input  logic                               res_ready
);

    localparam int SW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int NW     = $clog2(ENTRIES + 1);
    localparam int CDEPTH = ENTRIES * MAX_CANDIDATES;
    localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;

    function automatic logic [CAW-1:0] caddr(input logic [SW-1:0] s, input logic [2:0] c);
        caddr = CAW'(32'(s) * MAX_CANDIDATES + 32'(c));
    endfunction

    ent_t  ent_mem  [ENTRIES];
    cand_t cand_mem [CDEPTH];
    brk_t  brk_mem  [CDEPTH];
    ent_t  ent_q;
    cand_t cand_q;
    brk_t  brk_q;

    logic           ent_we, cand_we, brk_we;
    logic [SW-1:0]  ent_waddr, ent_raddr;
    logic [CAW-1:0] cand_waddr, cand_raddr;
    ent_t           ent_wdata;
    cand_t          cand_wdata;
    brk_t           brk_wdata;

    eng_state_t     state_reg, state_next;
    item_t          item_reg, item_next;
    logic [NW-1:0]  idx_reg, idx_next;
    logic           found_reg, found_next;
    logic [SW-1:0]  hit_reg, hit_next;
    logic [31:0]    hit_gen_reg, hit_gen_next;
    logic [2:0]     hit_cnt_reg, hit_cnt_next;
    logic           free_found_reg, free_found_next;
    logic [SW-1:0]  free_reg, free_next;
    logic [SW-1:0]  oldest_reg, oldest_next;
    logic [47:0]    oldest_ms_reg, oldest_ms_next;
    logic [SW-1:0]  slot_reg, slot_next;
    logic [2:0]     ci_reg, ci_next;
    logic           live_reg, live_next;
    logic [BO_W-1:0] bo_reg, bo_next;
    logic [7:0]     shifts_reg, shifts_next;
    brk_t           work_reg, work_next;
    logic [47:0]    exp_reg, exp_next;
    logic [31:0]    next_gen_reg, next_gen_next;
    logic [SW-1:0]  build_slot_reg, build_slot_next;
    logic           build_open_reg, build_open_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    result_t        res_reg, res_next;
    result_t        out_reg, out_next;
    logic           res_valid_reg, res_valid_next;

    logic [SW-1:0]  cur;
    logic           last_entry;
    logic [SW-1:0]  pick;
    brk_fam_t       bf;
    logic [7:0]     fails;
    logic [BO_W-1:0] capped;
    logic [48:0]    sum;

    assign cur        = idx_reg[SW-1:0];
    assign last_entry = (NW'(idx_reg + 1'b1) == used);
    assign ent_raddr  = (state_reg == E_BUILD_RD) ? build_slot_reg : cur;
    assign cand_raddr = caddr(slot_reg, ci_reg);
    assign res_valid  = res_valid_reg;
    assign res        = out_reg;

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (cand_we) begin
            cand_mem[cand_waddr] <= cand_wdata;
        end
        if (brk_we) begin
            brk_mem[cand_waddr] <= brk_wdata;
        end
        ent_q  <= ent_mem[ent_raddr];
        cand_q <= cand_mem[cand_raddr];
        brk_q  <= brk_mem[cand_raddr];
    end

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        hit_next        = hit_reg;
        hit_gen_next    = hit_gen_reg;
        hit_cnt_next    = hit_cnt_reg;
        free_found_next = free_found_reg;
        free_next       = free_reg;
        oldest_next     = oldest_reg;
        oldest_ms_next  = oldest_ms_reg;
        slot_next       = slot_reg;
        ci_next         = ci_reg;
        live_next       = live_reg;
        bo_next         = bo_reg;
        shifts_next     = shifts_reg;
        work_next       = work_reg;
        exp_next        = exp_reg;
        next_gen_next   = next_gen_reg;
        build_slot_next = build_slot_reg;
        build_open_next = build_open_reg;
        valid_next      = valid_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        res_valid_next  = res_valid_reg;
        q_pop           = 1'b0;
        ent_we          = 1'b0;
        cand_we         = 1'b0;
        brk_we          = 1'b0;
        ent_waddr       = slot_reg;
        cand_waddr      = caddr(slot_reg, ci_reg);
        ent_wdata       = ent_q;
        cand_wdata.host    = item_reg.host;
        cand_wdata.port    = item_reg.port;
        cand_wdata.expires = item_reg.expires;
        cand_wdata.persist = item_reg.persist;
        brk_wdata       = '0;
        pick            = oldest_reg;
        bf              = brk_q[item_reg.fam];
        fails           = 8'd0;
        capped          = (bo_reg > BO_W'(cfg.max_bo)) ? BO_W'(cfg.max_bo) : bo_reg;
        sum             = {1'b0, item_reg.now} + 49'(capped);

        if (res_valid_reg && res_ready) begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            E_IDLE: begin
                if (q_valid) begin
                    q_pop           = 1'b1;
                    item_next       = q_item;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    live_next       = 1'b0;
                    res_next        = '0;
                    res_next.status = STAT_IGN;
                    unique case (q_item.op)
                        OP_STORE: begin
                            state_next = (q_item.pos == 2'd0) ? E_SCAN_RD : E_BUILD_RD;
                        end
                        OP_CLEAR, OP_LOOKUP, OP_SUCCESS: state_next = E_SCAN_RD;
                        OP_FAIL: begin
                            state_next = (q_item.kind == KIND_IGNORED) ? E_RESP : E_SCAN_RD;
                        end
                        OP_NETCHG: state_next = E_NC_RD;
                        default:   state_next = E_RESP;
                    endcase
                end
            end
            E_SCAN_RD: state_next = E_SCAN_CHK;
            E_SCAN_CHK: begin
                // first key match, first free entry, and least recently updated
                if (valid_reg[cur] && ent_q.key == item_reg.key && !found_reg) begin
                    found_next   = 1'b1;
                    hit_next     = cur;
                    hit_gen_next = ent_q.gen;
                    hit_cnt_next = ent_q.count;
                end
                if (!valid_reg[cur] && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_next       = cur;
                end
                if (idx_reg == '0 || ent_q.updated < oldest_ms_reg) begin
                    oldest_next    = cur;
                    oldest_ms_next = ent_q.updated;
                end
                if (last_entry) begin
                    state_next = E_DISPATCH;
                end else begin
                    idx_next   = NW'(idx_reg + 1'b1);
                    state_next = E_SCAN_RD;
                end
            end
            E_DISPATCH: begin
                state_next = E_RESP;
                priority case (item_reg.op)
                    OP_STORE: begin
                        pick = found_reg ? hit_reg : (free_found_reg ? free_reg : oldest_reg);
                        ent_we            = 1'b1;
                        ent_waddr         = pick;
                        ent_wdata.key     = item_reg.key;
                        ent_wdata.gen     = next_gen_reg;
                        ent_wdata.updated = item_reg.now;
                        ent_wdata.count   = 3'd1;
                        cand_we           = 1'b1;
                        brk_we            = 1'b1;
                        cand_waddr        = caddr(pick, 3'd0);
                        valid_next[pick]  = 1'b1;
                        next_gen_next     = next_gen_reg + 32'd1;
                        build_slot_next   = pick;
                        build_open_next   = !item_reg.last;
                        res_next.status   = STAT_OK;
                    end
                    OP_CLEAR: begin
                        if (found_reg) begin
                            valid_next[hit_reg] = 1'b0;
                        end
                        res_next.status = STAT_OK;
                    end
                    OP_LOOKUP: begin
                        if (found_reg) begin
                            slot_next  = hit_reg;
                            ci_next    = 3'd0;
                            state_next = E_CAND_RD;
                        end else begin
                            res_next.status = STAT_MISS;
                        end
                    end
                    default: begin
                        // failure or success mark
                        if (found_reg && hit_gen_reg == item_reg.gen
                                && {1'b0, item_reg.pos} < hit_cnt_reg
                                && 32'(item_reg.pos) < MAX_CANDIDATES) begin
                            slot_next  = hit_reg;
                            ci_next    = {1'b0, item_reg.pos};
                            state_next = E_MARK_RD;
                        end
                    end
                endcase
            end
            E_BUILD_RD: state_next = E_BUILD_CHK;
            E_BUILD_CHK: begin
                state_next = E_RESP;
                if (build_open_reg && valid_reg[build_slot_reg]
                        && ent_q.key == item_reg.key
                        && ent_q.gen == next_gen_reg - 32'd1
                        && {1'b0, item_reg.pos} == ent_q.count
                        && 32'(item_reg.pos) < MAX_CANDIDATES) begin
                    ent_we          = 1'b1;
                    ent_waddr       = build_slot_reg;
                    ent_wdata.count = 3'({1'b0, item_reg.pos} + 3'd1);
                    cand_we         = 1'b1;
                    brk_we          = 1'b1;
                    cand_waddr      = caddr(build_slot_reg, {1'b0, item_reg.pos});
                    if (item_reg.last) begin
                        build_open_next = 1'b0;
                    end
                    res_next.status = STAT_OK;
                end else begin
                    build_open_next = 1'b0;
                end
            end
            E_CAND_RD: begin
                if (ci_reg < hit_cnt_reg && 32'(ci_reg) < MAX_CANDIDATES) begin
                    state_next = E_CAND_CHK;
                end else begin
                    // nothing usable; drop the entry when every candidate expired
                    if (!live_reg) begin
                        valid_next[slot_reg] = 1'b0;
                    end
                    res_next.status = STAT_MISS;
                    state_next      = E_RESP;
                end
            end
            E_CAND_CHK: begin
                if (cand_q.expires <= item_reg.now) begin
                    ci_next    = ci_reg + 3'd1;
                    state_next = E_CAND_RD;
                end else begin
                    live_next = 1'b1;
                    if (bf.disabled || bf.blk_until > item_reg.now) begin
                        ci_next    = ci_reg + 3'd1;
                        state_next = E_CAND_RD;
                    end else begin
                        res_next.status  = STAT_OK;
                        res_next.host    = cand_q.host;
                        res_next.port    = cand_q.port;
                        res_next.gen     = hit_gen_reg;
                        res_next.idx     = ci_reg[1:0];
                        res_next.persist = cand_q.persist;
                        state_next       = E_RESP;
                    end
                end
            end
            E_MARK_RD: state_next = E_MARK_CHK;
            E_MARK_CHK: begin
                work_next       = brk_q;
                exp_next        = cand_q.expires;
                res_next.status = STAT_OK;
                state_next      = E_RESP;
                if (item_reg.op == OP_SUCCESS) begin
                    brk_we                    = 1'b1;
                    brk_wdata                 = brk_q;
                    brk_wdata[item_reg.fam]   = '0;
                end else if (item_reg.kind == KIND_NETWORK) begin
                    fails = (bf.fails == 8'hFF) ? 8'hFF : bf.fails + 8'd1;
                    work_next[item_reg.fam].fails = fails;
                    bo_next     = BO_W'(cfg.init_bo);
                    shifts_next = (fails > 8'd1) ? fails - 8'd1 : 8'd0;
                    state_next  = E_BACKOFF;
                end else begin
                    brk_we                           = 1'b1;
                    brk_wdata                        = brk_q;
                    brk_wdata[item_reg.fam].disabled = 1'b1;
                end
            end
            E_BACKOFF: begin
                // one doubling per cycle until the limit or the count runs out
                if (shifts_reg != 8'd0 && bo_reg < BO_W'(cfg.max_bo)) begin
                    bo_next     = {bo_reg[BO_W-2:0], 1'b0};
                    shifts_next = shifts_reg - 8'd1;
                end else begin
                    state_next = E_MARK_WR;
                end
            end
            E_MARK_WR: begin
                brk_we    = 1'b1;
                brk_wdata = work_reg;
                if (sum[48] || sum[47:0] > exp_reg) begin
                    brk_wdata[item_reg.fam].blk_until = exp_reg;
                end else begin
                    brk_wdata[item_reg.fam].blk_until = sum[47:0];
                end
                state_next = E_RESP;
            end
            E_NC_RD: state_next = E_NC_CHK;
            E_NC_CHK: begin
                if (valid_reg[cur] && ent_q.count != 3'd0) begin
                    hit_cnt_next = ent_q.count;
                    slot_next    = cur;
                    ci_next      = 3'd0;
                    state_next   = E_NC_CLR;
                end else if (last_entry) begin
                    res_next.status = STAT_OK;
                    state_next      = E_RESP;
                end else begin
                    idx_next   = NW'(idx_reg + 1'b1);
                    state_next = E_NC_RD;
                end
            end
            E_NC_CLR: begin
                brk_we    = 1'b1;
                brk_wdata = '0;
                if (3'(ci_reg + 3'd1) >= hit_cnt_reg
                        || 32'(ci_reg) + 32'd1 >= MAX_CANDIDATES) begin
                    if (last_entry) begin
                        res_next.status = STAT_OK;
                        state_next      = E_RESP;
                    end else begin
                        idx_next   = NW'(idx_reg + 1'b1);
                        state_next = E_NC_RD;
                    end
                end else begin
                    ci_next = ci_reg + 3'd1;
                end
            end
            E_RESP: begin
                // output register loads only once the previous result is gone
                if (!res_valid_reg || res_ready) begin
                    res_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = E_IDLE;
                end
            end
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        idx_reg        <= idx_next;
        found_reg      <= found_next;
        hit_reg        <= hit_next;
        hit_gen_reg    <= hit_gen_next;
        hit_cnt_reg    <= hit_cnt_next;
        free_found_reg <= free_found_next;
        free_reg       <= free_next;
        oldest_reg     <= oldest_next;
        oldest_ms_reg  <= oldest_ms_next;
        slot_reg       <= slot_next;
        ci_reg         <= ci_next;
        live_reg       <= live_next;
        bo_reg         <= bo_next;
        shifts_reg     <= shifts_next;
        work_reg       <= work_next;
        exp_reg        <= exp_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= E_IDLE;
            next_gen_reg   <= 32'd1;
            build_slot_reg <= '0;
            build_open_reg <= 1'b0;
            valid_reg      <= '0;
            res_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            next_gen_reg   <= next_gen_next;
            build_slot_reg <= build_slot_next;
            build_open_reg <= build_open_next;
            valid_reg      <= valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

endmodule

### hdl/asc_checker.sv
// port-level checks on the alternative service cache, bound to the top level
`timescale 1ns / 1ps
`include "alt_service_candidate_cache_defines.svh"

module asc_checker
    import asc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    `ASC_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    `ASC_ASSERT_NEXT(a_reset_idle, aclk, 1'b1, !aresetn, !m_tvalid, "result valid right after reset")
    `ASC_ASSERT_IMPL(a_status, aclk, aresetn, m_tvalid, m_tdata[1:0] != 2'd3, "undefined status code")
    `ASC_ASSERT_IMPL(a_zero_fields, aclk, aresetn, m_tvalid && m_tdata[1:0] != STAT_OK, m_tdata[OUT_DATA_W-1:2] == '0, "found fields set without a hit")

endmodule

bind alt_service_candidate_cache asc_checker u_asc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### dv/alt_service_candidate_cache_tb.sv
// testbench of the alternative service candidate cache: predictor, checks and stimulus
`timescale 1ns / 1ps

module alt_service_candidate_cache_tb;
    import asc_pkg::*;

    localparam int NUM_ORIGINS = 16;
    localparam int NUM_CANDS   = 4;
    localparam int NUM_FAMS    = 3;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int POOL_SIZE   = 24;

    // codes the package leaves unnamed
    localparam logic [2:0]  ACT_RSVD_LO = 3'd6;
    localparam logic [2:0]  ACT_RSVD_HI = 3'd7;
    localparam logic [1:0]  KIND_OTHER  = 2'd2;
    localparam logic [1:0]  KIND_RSVD   = 2'd3;
    localparam logic [1:0]  FAM_RSVD    = 2'd3;
    localparam logic [47:0] TIME_MAX    = 48'hFFFF_FFFF_FFFF;

    // one input item, field by field
    typedef struct {
        logic [2:0]  act;
        logic [31:0] key;
        logic [47:0] now;
        logic [1:0]  fam;
        logic [1:0]  pos;
        logic [31:0] gen;
        logic [31:0] host;
        logic [15:0] port;
        logic [47:0] expires;
        logic        persist;
        logic        last;
        logic [1:0]  kind;
    } req_s;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    alt_service_candidate_cache dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // predicted cache contents and configuration
    // ---------------------------------------------------------------
    logic [4:0]  capacity_reg;
    logic [15:0] init_backoff;
    logic [21:0] max_backoff;

    logic        origin_valid   [NUM_ORIGINS];
    logic [31:0] origin_key     [NUM_ORIGINS];
    logic [31:0] origin_gen     [NUM_ORIGINS];
    logic [47:0] origin_updated [NUM_ORIGINS];
    logic [2:0]  origin_count   [NUM_ORIGINS];

    logic [31:0] alt_host    [NUM_ORIGINS*NUM_CANDS];
    logic [15:0] alt_port    [NUM_ORIGINS*NUM_CANDS];
    logic [47:0] alt_expires [NUM_ORIGINS*NUM_CANDS];
    logic        alt_persist [NUM_ORIGINS*NUM_CANDS];

    logic [47:0] blocked_until [NUM_ORIGINS*NUM_CANDS*NUM_FAMS];
    logic [7:0]  net_failures  [NUM_ORIGINS*NUM_CANDS*NUM_FAMS];
    logic        disabled      [NUM_ORIGINS*NUM_CANDS*NUM_FAMS];

    logic [31:0] gen_counter;
    int          run_slot;
    bit          run_open;

    result_t     pending_results[$];
    int          mismatches;
    int          cycle_count;
    bit          quiet;        // no idling on either side while set
    logic [47:0] clock_ms;
    logic [31:0] key_pool[POOL_SIZE];

    function automatic int slots_in_use();
        if (capacity_reg == 0) return 1;
        if (capacity_reg > NUM_ORIGINS) return NUM_ORIGINS;
        return capacity_reg;
    endfunction

    function automatic int find_origin(logic [31:0] key);
        for (int i = 0; i < slots_in_use(); i++)
            if (origin_valid[i] && origin_key[i] == key) return i;
        return -1;
    endfunction

    // free entry first, else the least recently updated one
    function automatic int victim_slot();
        int oldest;
        oldest = 0;
        for (int i = 0; i < slots_in_use(); i++) begin
            if (!origin_valid[i]) return i;
            if (origin_updated[i] < origin_updated[oldest]) oldest = i;
        end
        return oldest;
    endfunction

    function automatic void clear_broken_state(int ci);
        for (int f = 0; f < NUM_FAMS; f++) begin
            blocked_until[ci*NUM_FAMS+f] = '0;
            net_failures[ci*NUM_FAMS+f]  = '0;
            disabled[ci*NUM_FAMS+f]      = 1'b0;
        end
    endfunction

    function automatic void write_candidate(int slot, int pos, req_s r);
        int ci;
        ci = slot*NUM_CANDS + pos;
        alt_host[ci]    = r.host;
        alt_port[ci]    = r.port;
        alt_expires[ci] = r.expires;
        alt_persist[ci] = r.persist;
        clear_broken_state(ci);
        origin_count[slot] = 3'(pos + 1);
    endfunction

    function automatic logic [1:0] store_candidate(req_s r);
        int slot;
        if (r.pos == 0) begin
            slot = find_origin(r.key);
            if (slot < 0) slot = victim_slot();
            origin_valid[slot]   = 1'b1;
            origin_key[slot]     = r.key;
            origin_gen[slot]     = gen_counter;
            gen_counter          = gen_counter + 1;
            origin_updated[slot] = r.now;
            write_candidate(slot, 0, r);
            run_slot = slot;
            run_open = !r.last;
            return STAT_OK;
        end
        slot = run_slot;
        if (run_open && origin_valid[slot] && origin_key[slot] == r.key &&
            origin_gen[slot] == gen_counter - 1 && r.pos == origin_count[slot]) begin
            write_candidate(slot, r.pos, r);
            if (r.last) run_open = 1'b0;
            return STAT_OK;
        end
        run_open = 1'b0;
        return STAT_IGN;
    endfunction

    function automatic void find_candidate(req_s r, int fi, inout result_t res);
        int slot;
        int ci;
        int live;
        slot = find_origin(r.key);
        live = 0;
        res.status = STAT_MISS;
        if (slot < 0) return;
        for (int i = 0; i < origin_count[slot] && i < NUM_CANDS; i++) begin
            ci = slot*NUM_CANDS + i;
            if (alt_expires[ci] <= r.now) continue;
            live++;
            if (disabled[ci*NUM_FAMS+fi] || blocked_until[ci*NUM_FAMS+fi] > r.now) continue;
            res.status  = STAT_OK;
            res.host    = alt_host[ci];
            res.port    = alt_port[ci];
            res.gen     = origin_gen[slot];
            res.idx     = 2'(i);
            res.persist = alt_persist[ci];
            return;
        end
        if (live == 0) origin_valid[slot] = 1'b0;
    endfunction

    function automatic logic [1:0] mark_candidate(req_s r, int fi, bit success);
        int slot;
        int ci;
        int bi;
        int shifts;
        longint unsigned backoff;
        longint unsigned till;
        if (!success && r.kind == KIND_IGNORED) return STAT_IGN;
        slot = find_origin(r.key);
        if (slot < 0) return STAT_IGN;
        if (origin_gen[slot] != r.gen || r.pos >= origin_count[slot]) return STAT_IGN;
        ci = slot*NUM_CANDS + r.pos;
        bi = ci*NUM_FAMS + fi;
        if (success) begin
            blocked_until[bi] = '0;
            net_failures[bi]  = '0;
            disabled[bi]      = 1'b0;
        end else if (r.kind == KIND_NETWORK) begin
            if (net_failures[bi] != 8'hFF) net_failures[bi]++;
            backoff = init_backoff;
            shifts  = net_failures[bi] > 1 ? net_failures[bi] - 1 : 0;
            while (shifts != 0 && backoff < max_backoff) begin
                backoff = backoff * 2;
                shifts--;
            end
            if (backoff > max_backoff) backoff = max_backoff;
            till = longint'(r.now) + backoff;
            // past the 48-bit range or past expiry: block until expiry
            if (till > TIME_MAX || till > alt_expires[ci]) till = alt_expires[ci];
            blocked_until[bi] = till[47:0];
        end else begin
            disabled[bi] = 1'b1;
        end
        return STAT_OK;
    endfunction

    function automatic result_t predict_result(req_s r);
        result_t res;
        int fi;
        int slot;
        res = '0;
        fi  = (r.fam == FAM_IPV4 || r.fam == FAM_IPV6) ? r.fam : FAM_ANY;
        case (r.act)
            ACT_STORE: res.status = store_candidate(r);
            ACT_CLEAR: begin
                slot = find_origin(r.key);
                if (slot >= 0) origin_valid[slot] = 1'b0;
                res.status = STAT_OK;
            end
            ACT_LOOKUP:  find_candidate(r, fi, res);
            ACT_FAIL:    res.status = mark_candidate(r, fi, 1'b0);
            ACT_SUCCESS: res.status = mark_candidate(r, fi, 1'b1);
            ACT_NETCHG: begin
                for (int i = 0; i < slots_in_use(); i++)
                    if (origin_valid[i])
                        for (int c = 0; c < origin_count[i] && c < NUM_CANDS; c++)
                            clear_broken_state(i*NUM_CANDS + c);
                res.status = STAT_OK;
            end
            default: res.status = STAT_IGN;
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------
    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    // valid is left high when the next item follows at once
    task automatic send_item(req_s r);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= r.act;
        s_tlast  <= r.last;
        s_tdata  <= {1'b0, r.kind, r.persist, r.expires, r.port, r.host, r.gen,
                     r.pos, r.fam, r.now, r.key};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_result(r));
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() > 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_CAPACITY: capacity_reg = val[4:0];
            REG_INIT_BO:  init_backoff = val[15:0];
            REG_MAX_BO:   max_backoff  = val[21:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [4:0] cap, logic [15:0] ibo, logic [21:0] mbo);
        write_reg(REG_CAPACITY, CFG_DATA_W'(cap));
        write_reg(REG_INIT_BO, CFG_DATA_W'(ibo));
        write_reg(REG_MAX_BO, mbo);
    endtask

    // random content in every field, callers override what matters
    function automatic req_s noise_item();
        req_s r;
        r.act     = 3'($urandom_range(0, 7));
        r.key     = $urandom;
        r.now     = {16'($urandom), 32'($urandom)};
        r.fam     = 2'($urandom_range(0, 3));
        r.pos     = 2'($urandom_range(0, 3));
        r.gen     = $urandom;
        r.host    = $urandom;
        r.port    = 16'($urandom_range(1, 65535));
        r.expires = {16'($urandom), 32'($urandom)};
        r.persist = 1'($urandom);
        r.last    = 1'($urandom);
        r.kind    = 2'($urandom_range(0, 3));
        return r;
    endfunction

    function automatic req_s make_item(logic [2:0] act, logic [31:0] key);
        req_s r;
        r       = noise_item();
        r.act   = act;
        r.key   = key;
        r.now   = clock_ms;
        r.fam   = 2'($urandom_range(0, 2));
        r.kind  = KIND_NETWORK;
        r.expires = clock_ms + 48'($urandom_range(0, 30000));
        return r;
    endfunction

    function automatic logic [31:0] gen_of(logic [31:0] key);
        int slot;
        slot = find_origin(key);
        return slot < 0 ? 32'($urandom) : origin_gen[slot];
    endfunction

    // ---------------------------------------------------------------
    // result side: random stalls and checking
    // ---------------------------------------------------------------
    int hold_cycles;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready    <= 1'b0;
            hold_cycles = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                result_t got;
                result_t want;
                got = m_tdata[$bits(result_t)-1:0];
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h at %0t", got, $realtime);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp status %0d host %h port %h gen %h ",
                                      "idx %0d persist %0d, got status %0d host %h port %h ",
                                      "gen %h idx %0d persist %0d"},
                                     want.status, want.host, want.port, want.gen,
                                     want.idx, want.persist, got.status, got.host,
                                     got.port, got.gen, got.idx, got.persist);
                    end
                end
                hold_cycles = draw_gap();
            end
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("alt_service_candidate_cache_tb: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        req_s r;
        logic [31:0] ka;
        logic [31:0] kb;
        ka = 32'hA5A5_0001;
        kb = 32'h5A5A_FFFE;
        clock_ms = 48'd1000;
        // full store run with extreme field values
        for (int p = 0; p < 4; p++) begin
            r = make_item(ACT_STORE, ka);
            r.pos = 2'(p);
            r.last = (p == 3);
            r.host = p == 0 ? 32'hFFFF_FFFF : 32'h0;
            r.port = p == 0 ? 16'hFFFF : 16'd1;
            r.persist = (p == 0);
            r.expires = p == 0 ? TIME_MAX : p == 1 ? 48'd1500 : 48'd5000;
            send_item(r);
        end
        // continuation after the run closed is ignored
        r = make_item(ACT_STORE, ka);
        r.pos = 2'd1;
        send_item(r);
        r = make_item(ACT_LOOKUP, ka);
        r.fam = FAM_ANY;
        send_item(r);
        // network failure blocks candidate 0 for IPv4
        r = make_item(ACT_FAIL, ka);
        r.fam = FAM_IPV4; r.pos = 2'd0; r.gen = gen_of(ka); r.kind = KIND_NETWORK;
        send_item(r);
        send_item(r);
        r = make_item(ACT_LOOKUP, ka);
        r.fam = FAM_IPV4;
        send_item(r);
        // other failure and the reserved kind both disable
        r = make_item(ACT_FAIL, ka);
        r.fam = FAM_IPV6; r.pos = 2'd0; r.gen = gen_of(ka); r.kind = KIND_OTHER;
        send_item(r);
        r.fam = FAM_ANY; r.pos = 2'd1; r.kind = KIND_RSVD;
        send_item(r);
        r.kind = KIND_IGNORED;
        send_item(r);
        // stale generation
        r.kind = KIND_NETWORK; r.gen = gen_of(ka) + 1;
        send_item(r);
        r = make_item(ACT_SUCCESS, ka);
        r.fam = FAM_IPV4; r.pos = 2'd0; r.gen = gen_of(ka);
        send_item(r);
        r = make_item(ACT_NETCHG, ka);
        send_item(r);
        r = make_item(ACT_LOOKUP, ka);
        r.fam = FAM_RSVD;
        send_item(r);
        // every candidate expired frees the entry
        r.now = TIME_MAX;
        send_item(r);
        send_item(r);
        // one-candidate run near the end of time, backoff past 48 bits
        r = make_item(ACT_STORE, kb);
        r.pos = 2'd0; r.last = 1'b1; r.now = TIME_MAX - 5; r.expires = TIME_MAX;
        send_item(r);
        r = make_item(ACT_FAIL, kb);
        r.now = TIME_MAX - 5; r.pos = 2'd0; r.gen = gen_of(kb);
        send_item(r);
        r.pos = 2'd1;    // beyond the candidate count
        send_item(r);
        r = make_item(ACT_CLEAR, kb);
        send_item(r);
        r = make_item(ACT_LOOKUP, kb);
        send_item(r);
        r = make_item(ACT_SUCCESS, kb);
        send_item(r);
        r = make_item(ACT_RSVD_LO, ka);
        send_item(r);
        r = make_item(ACT_RSVD_HI, ka);
        send_item(r);
    endtask

    task automatic test_random(int num_items);
        req_s r;
        int sent;
        int pick;
        int len;
        logic [31:0] key;
        sent = 0;
        while (sent < num_items) begin
            if ($urandom_range(0, 15) == 0) quiet = ~quiet;
            clock_ms = clock_ms + 48'($urandom_range(0, 2500));
            key  = key_pool[$urandom_range(0, POOL_SIZE-1)];
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                // store run, sometimes broken
                len = $urandom_range(1, 4);
                for (int p = 0; p < len; p++) begin
                    r = make_item(ACT_STORE, key);
                    r.pos  = 2'(p);
                    r.last = (p == len - 1);
                    if ($urandom_range(0, 19) == 0) r.pos = 2'($urandom_range(0, 3));
                    if ($urandom_range(0, 29) == 0) r.key = key_pool[0];
                    if ($urandom_range(0, 9) == 0) r.last = 1'($urandom);
                    send_item(r);
                    sent++;
                end
            end else if (pick < 65) begin
                r = make_item(ACT_LOOKUP, key);
                if ($urandom_range(0, 9) == 0) r.fam = FAM_RSVD;
                send_item(r);
                sent++;
            end else if (pick < 88) begin
                r = make_item($urandom_range(0, 2) == 0 ? ACT_SUCCESS : ACT_FAIL, key);
                r.gen = $urandom_range(0, 9) == 0 ? $urandom : gen_of(key);
                r.pos = 2'($urandom_range(0, 3));
                pick = $urandom_range(0, 9);
                r.kind = pick < 6 ? KIND_NETWORK : pick < 8 ? KIND_OTHER :
                         pick < 9 ? KIND_RSVD : KIND_IGNORED;
                send_item(r);
                sent++;
            end else if (pick < 93) begin
                send_item(make_item(ACT_CLEAR, key));
                sent++;
            end else if (pick < 96) begin
                send_item(make_item(ACT_NETCHG, key));
                sent++;
            end else begin
                send_item(noise_item());
                sent++;
            end
        end
        quiet = 1'b0;
    endtask

    task automatic test_config_sweep();
        set_config(5'd1, 16'd1, 22'd1);
        test_random(110);
        set_config(5'd0, 16'hFFFF, 22'h3F_FFFF);
        test_random(110);
        set_config(5'd31, 16'd3, 22'd100);
        test_random(130);
        set_config(5'd5, 16'd1000, 22'd60000);
        test_random(110);
        set_config(5'd16, 16'd1, 22'h3F_FFFF);
        test_random(110);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        mismatches  = 0;
        cycle_count = 0;
        quiet       = 1'b0;
        capacity_reg = CAP_RESET;
        init_backoff = INIT_BO_RESET;
        max_backoff  = MAX_BO_RESET;
        gen_counter  = 32'd1;
        run_slot     = 0;
        run_open     = 1'b0;
        foreach (origin_valid[i]) origin_valid[i] = 1'b0;
        foreach (blocked_until[i]) begin
            blocked_until[i] = '0;
            net_failures[i]  = '0;
            disabled[i]      = 1'b0;
        end
        foreach (key_pool[i]) key_pool[i] = $urandom;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(200);
        test_config_sweep();

        wait_idle();
        if (mismatches == 0) begin
            $display("alt_service_candidate_cache_tb: PASS");
        end else begin
            $display("alt_service_candidate_cache_tb: FAIL");
        end
        $finish;
    end

endmodule

### alt_service_candidate_cache.f
+incdir+hdl
hdl/asc_pkg.sv
hdl/asc_front.sv
hdl/asc_engine.sv
hdl/alt_service_candidate_cache.sv
hdl/asc_checker.sv
dv/alt_service_candidate_cache_tb.sv
